### hw/rtl/ecnwcc_pkg.sv
// Shared constants, types and update codes of the ECN window congestion control block.
// Depends on nothing; used by ecnwcc_flow_mem, ecnwcc_update and the top level.
package ecnwcc_pkg;

	// Default configuration of the top level.
	localparam int FLOW_COUNT_DEF     = 256;
	localparam int ECN_WINDOW_DEF     = 8;
	localparam int INITIAL_WINDOW_DEF = 1;

	// Fixed field widths.
	localparam int FLOW_W  = 8;
	localparam int WIN_W   = 16;
	localparam int KIND_W  = 2;
	localparam int MARKS_W = 6;

	// Flows reachable through an 8-bit flow number.
	localparam int FLOW_SPAN = 1 << FLOW_W;

	localparam logic [WIN_W-1:0] THR_RESET = 16'd64;
	localparam logic [WIN_W-1:0] WIN_MAX   = 16'hFFFF;

	// Fixed-point fraction count/window: exact for 16-bit windows and windows of up to 32 marks.
	localparam int FRAC_SHIFT = WIN_W + 5;
	localparam int FRAC_W     = FRAC_SHIFT + 1;

	typedef enum logic [KIND_W-1:0] {
		UPD_REDUCED    = 2'd0,
		UPD_SLOW_START = 2'd1,
		UPD_ADD_INC    = 2'd2,
		UPD_COUNTED    = 2'd3
	} upd_kind_t;

endpackage

### hw/rtl/ecnwcc_flow_mem.sv
// Per-flow state store: window, ack counter, mark history and history pointer.
// Registered read with valid bits for reset values and a bypass of the write in flight.
// Depends on ecnwcc_pkg.
module ecnwcc_flow_mem #(
	parameter int MEM_DEPTH      = ecnwcc_pkg::FLOW_COUNT_DEF,
	parameter int ECN_WINDOW     = ecnwcc_pkg::ECN_WINDOW_DEF,
	parameter int INITIAL_WINDOW = ecnwcc_pkg::INITIAL_WINDOW_DEF,
	parameter int IDX_W          = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1,
	parameter int PTR_W          = $clog2(ECN_WINDOW)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic [IDX_W-1:0]               rd_idx,
	input  logic                           wr_en,
	input  logic [IDX_W-1:0]               wr_idx,
	input  logic [ecnwcc_pkg::WIN_W-1:0]   wr_win,
	input  logic [ecnwcc_pkg::WIN_W-1:0]   wr_ack,
	input  logic [ECN_WINDOW-1:0]          wr_hist,
	input  logic [PTR_W-1:0]               wr_ptr,
	output logic [ecnwcc_pkg::WIN_W-1:0]   rd_win,
	output logic [ecnwcc_pkg::WIN_W-1:0]   rd_ack,
	output logic [ECN_WINDOW-1:0]          rd_hist,
	output logic [PTR_W-1:0]               rd_ptr
);

	localparam logic [ecnwcc_pkg::WIN_W-1:0] WIN_RESET = ecnwcc_pkg::WIN_W'(INITIAL_WINDOW);

	logic [ecnwcc_pkg::WIN_W-1:0] win_mem  [MEM_DEPTH];
	logic [ecnwcc_pkg::WIN_W-1:0] ack_mem  [MEM_DEPTH];
	logic [ECN_WINDOW-1:0]        hist_mem [MEM_DEPTH];
	logic [PTR_W-1:0]             ptr_mem  [MEM_DEPTH];
	logic [MEM_DEPTH-1:0]         vld_q;

	logic [ecnwcc_pkg::WIN_W-1:0] win_rd_q, ack_rd_q, win_lw_q, ack_lw_q;
	logic [ECN_WINDOW-1:0]        hist_rd_q, hist_lw_q;
	logic [PTR_W-1:0]             ptr_rd_q, ptr_lw_q;
	logic                         vld_rd_q, byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			win_mem[wr_idx]  <= wr_win;
			ack_mem[wr_idx]  <= wr_ack;
			hist_mem[wr_idx] <= wr_hist;
			ptr_mem[wr_idx]  <= wr_ptr;
		end
		if (rd_en) begin
			win_rd_q  <= win_mem[rd_idx];
			ack_rd_q  <= ack_mem[rd_idx];
			hist_rd_q <= hist_mem[rd_idx];
			ptr_rd_q  <= ptr_mem[rd_idx];
		end
	end

	// Keep the last written entry for a read issued on the same edge.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			win_lw_q  <= wr_win;
			ack_lw_q  <= wr_ack;
			hist_lw_q <= wr_hist;
			ptr_lw_q  <= wr_ptr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
			byp_q    <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_idx] <= 1'b1;
			if (rd_en) begin
				vld_rd_q <= vld_q[rd_idx];
				byp_q    <= wr_en && (wr_idx == rd_idx);
			end
		end
	end

	always_comb begin
		if (byp_q) begin
			rd_win  = win_lw_q;
			rd_ack  = ack_lw_q;
			rd_hist = hist_lw_q;
			rd_ptr  = ptr_lw_q;
		end else if (vld_rd_q) begin
			rd_win  = win_rd_q;
			rd_ack  = ack_rd_q;
			rd_hist = hist_rd_q;
			rd_ptr  = ptr_rd_q;
		end else begin
			rd_win  = WIN_RESET;
			rd_ack  = '0;
			rd_hist = '0;
			rd_ptr  = '0;
		end
	end

endmodule

### hw/rtl/ecnwcc_update.sv
// Window update datapath for one acknowledgement: history insert, mark count, reduce/grow.
// Depends on ecnwcc_pkg.
module ecnwcc_update #(
	parameter int ECN_WINDOW = ecnwcc_pkg::ECN_WINDOW_DEF,
	parameter int PTR_W      = $clog2(ECN_WINDOW),
	parameter int CNT_W      = $clog2(ECN_WINDOW + 1)
) (
	input  logic [ecnwcc_pkg::WIN_W-1:0] win,
	input  logic [ecnwcc_pkg::WIN_W-1:0] ack,
	input  logic [ECN_WINDOW-1:0]        hist,
	input  logic [PTR_W-1:0]             ptr,
	input  logic                         mark,
	input  logic [ecnwcc_pkg::WIN_W-1:0] thr,
	output logic [ecnwcc_pkg::WIN_W-1:0] win_nxt,
	output logic [ecnwcc_pkg::WIN_W-1:0] ack_nxt,
	output logic [ECN_WINDOW-1:0]        hist_nxt,
	output logic [PTR_W-1:0]             ptr_nxt,
	output ecnwcc_pkg::upd_kind_t        kind,
	output logic [CNT_W-1:0]             count
);

	localparam int WIN_W = ecnwcc_pkg::WIN_W;
	localparam int FRAC_W = ecnwcc_pkg::FRAC_W;
	localparam int FRAC_SHIFT = ecnwcc_pkg::FRAC_SHIFT;
	localparam logic [PTR_W:0]   WIN_LEN  = (PTR_W + 1)'(ECN_WINDOW);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ECN_WINDOW - 1);

	// frac_tab[c] = ceil(c * 2^FRAC_SHIFT / ECN_WINDOW)
	logic [FRAC_W-1:0] frac_tab [ECN_WINDOW + 1];

	for (genvar c = 0; c <= ECN_WINDOW; c++) begin : g_frac
		localparam longint unsigned FV =
			((longint'(c) << FRAC_SHIFT) + longint'(ECN_WINDOW) - 1) / ECN_WINDOW;
		assign frac_tab[c] = FRAC_W'(FV);
	end

	function automatic logic [CNT_W-1:0] pop_count(input logic [ECN_WINDOW-1:0] bits);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < ECN_WINDOW; i++)
			n = n + CNT_W'(bits[i]);
		return n;
	endfunction

	logic [PTR_W-1:0]         ptr_eff;
	logic [WIN_W+FRAC_W-1:0]  prod;
	logic [WIN_W-1:0]         win_red, win_sub;
	logic [WIN_W:0]           win_dbl, ack_inc;

	always_comb begin
		ptr_eff = ({1'b0, ptr} >= WIN_LEN) ? '0 : ptr;
		hist_nxt = hist;
		hist_nxt[ptr_eff] = mark;
		count = pop_count(hist_nxt);
		ptr_nxt = (ptr_eff == PTR_LAST) ? '0 : ptr_eff + 1'b1;

		// Reduction: window * count / ECN_WINDOW through the fixed-point fraction.
		prod    = (WIN_W + FRAC_W)'(win) * (WIN_W + FRAC_W)'(frac_tab[count]);
		win_red = prod[FRAC_SHIFT +: WIN_W];
		win_sub = win - win_red;

		win_dbl = {win, 1'b0};
		ack_inc = {1'b0, ack} + 1'b1;

		ack_nxt = ack;
		if (mark) begin
			win_nxt = (win_sub == '0) ? WIN_W'(1) : win_sub;
			kind    = ecnwcc_pkg::UPD_REDUCED;
		end else if (win < thr) begin
			win_nxt = win_dbl[WIN_W] ? ecnwcc_pkg::WIN_MAX : win_dbl[WIN_W-1:0];
			kind    = ecnwcc_pkg::UPD_SLOW_START;
		end else begin
			ack_nxt = ack_inc[WIN_W] ? ecnwcc_pkg::WIN_MAX : ack_inc[WIN_W-1:0];
			if (ack_nxt >= win) begin
				win_nxt = (win == ecnwcc_pkg::WIN_MAX) ? win : win + 1'b1;
				ack_nxt = '0;
				kind    = ecnwcc_pkg::UPD_ADD_INC;
			end else begin
				win_nxt = win;
				kind    = ecnwcc_pkg::UPD_COUNTED;
			end
		end
	end

endmodule

### hw/rtl/ecn_window_congestion_control_top.sv
// Top level of the ECN window congestion control block: handshakes, threshold register,
// input stage and result register. Depends on ecnwcc_pkg, ecnwcc_flow_mem, ecnwcc_update.
//
// Channel   Dir  Handshake                 Word
// -------   ---  ------------------------  --------------------------------------------
// in        in   in_valid / in_stall       flow_number, congestion_mark
// out       out  out_valid / out_stall     result_flow, new_window, update_kind,
//                                          marks_in_window
// cfg       in   cfg_valid / cfg_ready     cfg_data (slow start threshold)
//
// Words are taken one per cycle while in_stall is low; results leave the result register.
// The per-flow state memory read is registered, and the update runs in the cycle after it.
// Back-to-back words of one flow see the previous update through a bypass in the store.
// Reset clears the valid bits of all entries at once, so no clearing pass is needed.
// in_stall rises only while the input stage holds a word and the result register is stalled.
module ecn_window_congestion_control_top #(
	parameter int FLOW_COUNT     = ecnwcc_pkg::FLOW_COUNT_DEF,
	parameter int ECN_WINDOW     = ecnwcc_pkg::ECN_WINDOW_DEF,
	parameter int INITIAL_WINDOW = ecnwcc_pkg::INITIAL_WINDOW_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// acknowledgement channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [ecnwcc_pkg::FLOW_W-1:0]    flow_number,
	input  logic                             congestion_mark,
	// result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [ecnwcc_pkg::FLOW_W-1:0]    result_flow,
	output logic [ecnwcc_pkg::WIN_W-1:0]     new_window,
	output logic [ecnwcc_pkg::KIND_W-1:0]    update_kind,
	output logic [ecnwcc_pkg::MARKS_W-1:0]   marks_in_window,
	// threshold write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ecnwcc_pkg::WIN_W-1:0]     cfg_data
);

	// Only flows reachable by an 8-bit flow number need storage.
	localparam int MEM_DEPTH = (FLOW_COUNT < ecnwcc_pkg::FLOW_SPAN) ?
		FLOW_COUNT : ecnwcc_pkg::FLOW_SPAN;
	localparam int IDX_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int PTR_W = $clog2(ECN_WINDOW);
	localparam int CNT_W = $clog2(ECN_WINDOW + 1);

	// Map flow number to table entry (flow number modulo FLOW_COUNT).
	logic [IDX_W-1:0] flow_idx_tab [ecnwcc_pkg::FLOW_SPAN];

	for (genvar i = 0; i < ecnwcc_pkg::FLOW_SPAN; i++) begin : g_idx
		localparam int MI = i % FLOW_COUNT;
		assign flow_idx_tab[i] = IDX_W'(MI);
	end

	logic [ecnwcc_pkg::WIN_W-1:0] thr_q;

	logic                          v_s1;
	logic [ecnwcc_pkg::FLOW_W-1:0] flow_s1;
	logic [IDX_W-1:0]              idx_s1;
	logic                          mark_s1;

	logic                          out_valid_q;
	logic [ecnwcc_pkg::FLOW_W-1:0] flow_s2;
	logic [ecnwcc_pkg::WIN_W-1:0]  win_s2;
	ecnwcc_pkg::upd_kind_t         kind_s2;
	logic [CNT_W-1:0]              cnt_s2;

	logic in_accept, out_free, adv_s1;

	logic [ecnwcc_pkg::WIN_W-1:0] cur_win, cur_ack, nxt_win, nxt_ack;
	logic [ECN_WINDOW-1:0]        cur_hist, nxt_hist;
	logic [PTR_W-1:0]             cur_ptr, nxt_ptr;
	ecnwcc_pkg::upd_kind_t        nxt_kind;
	logic [CNT_W-1:0]             nxt_cnt;

	// Advance the input stage whenever the result register is empty or draining.
	assign out_free  = !out_valid_q || !out_stall;
	assign adv_s1    = v_s1 && out_free;
	assign in_stall  = v_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ecnwcc_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept)
				v_s1 <= 1'b1;
			else if (adv_s1)
				v_s1 <= 1'b0;
			if (adv_s1)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Capture the word; the state read is issued on the same edge.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			flow_s1 <= flow_number;
			idx_s1  <= flow_idx_tab[flow_number];
			mark_s1 <= congestion_mark;
		end
		if (adv_s1) begin
			flow_s2 <= flow_s1;
			win_s2  <= nxt_win;
			kind_s2 <= nxt_kind;
			cnt_s2  <= nxt_cnt;
		end
	end

	ecnwcc_flow_mem #(
		.MEM_DEPTH      (MEM_DEPTH),
		.ECN_WINDOW     (ECN_WINDOW),
		.INITIAL_WINDOW (INITIAL_WINDOW),
		.IDX_W          (IDX_W),
		.PTR_W          (PTR_W)
	) u_flow_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_accept),
		.rd_idx  (flow_idx_tab[flow_number]),
		.wr_en   (adv_s1),
		.wr_idx  (idx_s1),
		.wr_win  (nxt_win),
		.wr_ack  (nxt_ack),
		.wr_hist (nxt_hist),
		.wr_ptr  (nxt_ptr),
		.rd_win  (cur_win),
		.rd_ack  (cur_ack),
		.rd_hist (cur_hist),
		.rd_ptr  (cur_ptr)
	);

	ecnwcc_update #(
		.ECN_WINDOW (ECN_WINDOW),
		.PTR_W      (PTR_W),
		.CNT_W      (CNT_W)
	) u_update (
		.win      (cur_win),
		.ack      (cur_ack),
		.hist     (cur_hist),
		.ptr      (cur_ptr),
		.mark     (mark_s1),
		.thr      (thr_q),
		.win_nxt  (nxt_win),
		.ack_nxt  (nxt_ack),
		.hist_nxt (nxt_hist),
		.ptr_nxt  (nxt_ptr),
		.kind     (nxt_kind),
		.count    (nxt_cnt)
	);

	assign out_valid       = out_valid_q;
	assign result_flow     = flow_s2;
	assign new_window      = win_s2;
	assign update_kind     = kind_s2;
	assign marks_in_window = ecnwcc_pkg::MARKS_W'(cnt_s2);

`ifndef SYNTHESIS
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1)
		else $error("input stalled with empty input stage");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid)
		else $error("advanced word did not reach result register");

	a_window_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> new_window != '0)
		else $error("zero congestion window delivered");

	a_marks_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> marks_in_window <= ecnwcc_pkg::MARKS_W'(ECN_WINDOW))
		else $error("mark count exceeds history length");

	a_reduced_has_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && update_kind == ecnwcc_pkg::UPD_REDUCED |-> marks_in_window != '0)
		else $error("reduction without a mark in history");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for ecn_window_congestion_control_top: per-flow window updates on ACK words.
// Depends on ecnwcc_pkg and the top level; holds its own window model and a queue of due updates.
module testbench;

	localparam int FLOW_W        = ecnwcc_pkg::FLOW_W;
	localparam int WIN_W         = ecnwcc_pkg::WIN_W;
	localparam int KIND_W        = ecnwcc_pkg::KIND_W;
	localparam int MARKS_W       = ecnwcc_pkg::MARKS_W;
	localparam int FLOWS         = ecnwcc_pkg::FLOW_COUNT_DEF;
	localparam int MARK_SPAN     = ecnwcc_pkg::ECN_WINDOW_DEF;
	localparam int HOLD_CYCLES   = 60;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PRINT_CAP     = 40;

	typedef enum {JOB_ACK, JOB_THRESHOLD, JOB_DRAIN, JOB_PACE, JOB_HOLD} job_kind_t;

	// One entry of the stimulus plan: an ACK word, a threshold write or a control step.
	typedef struct {
		job_kind_t         kind;
		logic [FLOW_W-1:0] flow;
		logic              mark;
		logic [WIN_W-1:0]  value;
		int                idle_pct;
		int                stall_pct;
	} job_t;

	typedef struct {
		logic [FLOW_W-1:0]     flow;
		logic [WIN_W-1:0]      window;
		ecnwcc_pkg::upd_kind_t kind;
		logic [MARKS_W-1:0]    marks;
	} window_update_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [FLOW_W-1:0]    flow_number = '0;
	logic                 congestion_mark = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [FLOW_W-1:0]    result_flow;
	logic [WIN_W-1:0]     new_window;
	logic [KIND_W-1:0]    update_kind;
	logic [MARKS_W-1:0]   marks_in_window;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [WIN_W-1:0]     cfg_data = '0;

	job_t           ack_plan[$];
	window_update_t updates_due[$];
	int             updates_in_flight = 0;
	int             bad_words = 0;
	int             cycle_count = 0;
	int             stall_pct = 0;
	int             hold_left = 0;
	logic           hold_req = 1'b0;

	// Model state: one window, ACK counter, mark history and write pointer per flow.
	logic [WIN_W-1:0] window_model[FLOWS];
	logic [WIN_W-1:0] acks_model[FLOWS];
	logic [31:0]      history_model[FLOWS];
	int unsigned      pointer_model[FLOWS];
	logic [WIN_W-1:0] threshold_model;

	ecn_window_congestion_control_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.flow_number     (flow_number),
		.congestion_mark (congestion_mark),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_flow     (result_flow),
		.new_window      (new_window),
		.update_kind     (update_kind),
		.marks_in_window (marks_in_window),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hold reset at the start, then release it once and for all.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Record the mark, shrink on a marked ACK, double below the threshold,
	// otherwise count ACKs and add one once the count reaches the window.
	function automatic window_update_t predict_window_update(logic [FLOW_W-1:0] flow,
			logic mark);
		int unsigned    slot;
		int unsigned    ptr;
		int unsigned    marks;
		int unsigned    win;
		int unsigned    acks;
		logic [31:0]    hist;
		window_update_t upd;
		slot = flow % FLOWS;
		ptr = pointer_model[slot];
		if (ptr >= MARK_SPAN)
			ptr = 0;
		hist = history_model[slot];
		hist[ptr] = mark;
		hist &= 32'((64'd1 << MARK_SPAN) - 64'd1);
		history_model[slot] = hist;
		marks = $countones(hist);
		win = window_model[slot];
		if (mark) begin
			win = win - (win * marks) / MARK_SPAN;
			if (win < 1)
				win = 1;
			upd.kind = ecnwcc_pkg::UPD_REDUCED;
		end else if (win < threshold_model) begin
			win = win * 2;
			if (win > ecnwcc_pkg::WIN_MAX)
				win = ecnwcc_pkg::WIN_MAX;
			upd.kind = ecnwcc_pkg::UPD_SLOW_START;
		end else begin
			acks = acks_model[slot] + 1;
			if (acks > ecnwcc_pkg::WIN_MAX)
				acks = ecnwcc_pkg::WIN_MAX;
			// a counter left above the window by a reduction fires right away
			if (acks >= win) begin
				if (win < ecnwcc_pkg::WIN_MAX)
					win++;
				acks = 0;
				upd.kind = ecnwcc_pkg::UPD_ADD_INC;
			end else begin
				upd.kind = ecnwcc_pkg::UPD_COUNTED;
			end
			acks_model[slot] = acks[WIN_W-1:0];
		end
		window_model[slot] = win[WIN_W-1:0];
		pointer_model[slot] = (ptr + 1) % MARK_SPAN;
		upd.flow = flow;
		upd.window = win[WIN_W-1:0];
		upd.marks = marks[MARKS_W-1:0];
		return upd;
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		if (bad_words < PRINT_CAP)
			$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
				want);
		bad_words++;
	endtask

	function automatic void push_job(job_kind_t kind, logic [FLOW_W-1:0] flow, logic mark,
			logic [WIN_W-1:0] value, int idle_pct, int stall);
		job_t j;
		j.kind = kind;
		j.flow = flow;
		j.mark = mark;
		j.value = value;
		j.idle_pct = idle_pct;
		j.stall_pct = stall;
		ack_plan.push_back(j);
	endfunction

	function automatic void push_ack(logic [FLOW_W-1:0] flow, logic mark);
		push_job(JOB_ACK, flow, mark, '0, 0, 0);
	endfunction

	// Write a threshold, set the idling mix, then queue random ACK words.
	// Most words hit a handful of flows so windows get deep; some bursts mark a
	// whole history so the window collapses to one.
	function automatic void add_phase(logic [WIN_W-1:0] thr, int idle_pct, int stall, int n);
		int               left;
		logic [FLOW_W-1:0] f;
		push_job(JOB_THRESHOLD, '0, 1'b0, thr, 0, 0);
		push_job(JOB_PACE, '0, 1'b0, '0, idle_pct, stall);
		left = n;
		while (left > 0) begin
			if ($urandom_range(99) < 70)
				f = FLOW_W'($urandom_range(7));
			else
				f = FLOW_W'($urandom_range(255));
			if ($urandom_range(99) < 4 && left >= MARK_SPAN) begin
				repeat (MARK_SPAN) push_ack(f, 1'b1);
				left -= MARK_SPAN;
			end else begin
				push_ack(f, $urandom_range(99) < 25);
				left--;
			end
		end
	endfunction

	// Build the plan, then wait for the plan and every due update to drain.
	initial begin
		// Saturate flow 255 by doubling, mark its whole history, then count
		// past the window with a threshold of zero.
		push_job(JOB_PACE, '0, 1'b0, '0, 0, 0);
		push_job(JOB_THRESHOLD, '0, 1'b0, ecnwcc_pkg::WIN_MAX, 0, 0);
		repeat (17) push_ack(8'd255, 1'b0);
		repeat (MARK_SPAN) push_ack(8'd255, 1'b1);
		push_job(JOB_THRESHOLD, '0, 1'b0, '0, 0, 0);
		push_ack(8'd255, 1'b0);
		push_ack(8'd0, 1'b1);

		add_phase(ecnwcc_pkg::THR_RESET, 0, 0, 150);
		// Stall the result side for a long stretch while words keep coming,
		// then pause the sender until every update is back.
		push_job(JOB_PACE, '0, 1'b0, '0, 0, 0);
		push_job(JOB_HOLD, '0, 1'b0, '0, 0, 0);
		repeat (40) push_ack(FLOW_W'($urandom_range(3)), $urandom_range(99) < 25);
		push_job(JOB_DRAIN, '0, 1'b0, '0, 0, 0);
		add_phase(16'd1, 67, 0, 150);
		add_phase(WIN_W'($urandom_range(40, 2)), 0, 67, 150);
		add_phase(WIN_W'($urandom_range(4000, 100)), 14, 14, 150);
		add_phase(ecnwcc_pkg::WIN_MAX, 0, 0, 150);
		add_phase(WIN_W'($urandom_range(200, 8)), 67, 0, 150);

		wait (arst_n);
		@(negedge clk);
		while (ack_plan.size() != 0 || in_valid || cfg_valid || updates_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (bad_words == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Driver: offer plan entries; hold a stalled word or a pending write until it is taken.
	always @(posedge clk or negedge arst_n) begin : driver_p
		logic accepted;
		logic offer;
		logic cfg_busy;
		logic stop;
		logic want_hold;
		int   send_idle;
		int   next_stall;
		if (!arst_n) begin
			in_valid <= 1'b0;
			flow_number <= '0;
			congestion_mark <= 1'b0;
			cfg_valid <= 1'b0;
			cfg_data <= '0;
			hold_req <= 1'b0;
			stall_pct <= 0;
			send_idle = 0;
			next_stall = 0;
		end else begin
			accepted = in_valid && !in_stall;
			offer = in_valid && !accepted;
			cfg_busy = cfg_valid && !cfg_ready;
			want_hold = 1'b0;
			stop = offer || cfg_busy;
			while (!stop && ack_plan.size() != 0) begin
				case (ack_plan[0].kind)
					JOB_PACE: begin
						send_idle = ack_plan[0].idle_pct;
						next_stall = ack_plan[0].stall_pct;
						ack_plan.delete(0);
					end
					JOB_HOLD: begin
						want_hold = 1'b1;
						ack_plan.delete(0);
					end
					JOB_DRAIN: begin
						if (updates_in_flight == 0 && !accepted)
							ack_plan.delete(0);
						else
							stop = 1'b1;
					end
					JOB_THRESHOLD: begin
						// write only with the block empty
						if (updates_in_flight == 0 && !accepted) begin
							cfg_data <= ack_plan[0].value;
							cfg_busy = 1'b1;
							ack_plan.delete(0);
						end
						stop = 1'b1;
					end
					JOB_ACK: begin
						if ($urandom_range(99) >= send_idle) begin
							flow_number <= ack_plan[0].flow;
							congestion_mark <= ack_plan[0].mark;
							offer = 1'b1;
							ack_plan.delete(0);
						end
						stop = 1'b1;
					end
				endcase
			end
			in_valid <= offer;
			cfg_valid <= cfg_busy;
			hold_req <= want_hold;
			stall_pct <= next_stall;
		end
	end

	// Count down the long hold-off of the result side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_req)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
	end

	// Monitor: check each taken result word against the oldest due update, then
	// predict for each taken ACK word and track threshold writes.
	always @(posedge clk or negedge arst_n) begin : monitor_p
		window_update_t want;
		int             i;
		if (!arst_n) begin
			for (i = 0; i < FLOWS; i++) begin
				window_model[i] = WIN_W'(ecnwcc_pkg::INITIAL_WINDOW_DEF);
				acks_model[i] = '0;
				history_model[i] = '0;
				pointer_model[i] = 0;
			end
			threshold_model = ecnwcc_pkg::THR_RESET;
			updates_in_flight <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (updates_due.size() == 0) begin
					flag_mismatch("unexpected word, result_flow", result_flow, -1);
				end else begin
					want = updates_due.pop_front();
					if (result_flow !== want.flow)
						flag_mismatch("result_flow", result_flow, want.flow);
					if (new_window !== want.window)
						flag_mismatch("new_window", new_window, want.window);
					if (update_kind !== want.kind)
						flag_mismatch("update_kind", update_kind, int'(want.kind));
					if (marks_in_window !== want.marks)
						flag_mismatch("marks_in_window", marks_in_window, want.marks);
				end
			end
			if (in_valid && !in_stall)
				updates_due.push_back(predict_window_update(flow_number, congestion_mark));
			if (cfg_valid && cfg_ready)
				threshold_model = cfg_data;
			updates_in_flight <= updates_due.size();
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule

### ecn_window_congestion_control_top.f
hw/rtl/ecnwcc_pkg.sv
hw/rtl/ecnwcc_flow_mem.sv
hw/rtl/ecnwcc_update.sv
hw/rtl/ecn_window_congestion_control_top.sv
verif/testbench.sv
